### src/kwm_pkg.sv
// Shared constants and types for the k-mer k-way merge unit.
package kwm_pkg;

    localparam int SOURCES_DEF   = 16;
    localparam int KEY_BASES_DEF = 21;

    localparam int SRC_W       = 4;
    localparam int SRC_REACH   = 16;
    localparam int KEY_FIELD_W = 42;
    localparam int POS_W       = 32;
    localparam int CFG_W       = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

endpackage

### src/kwm_head_ram.sv
// Head record store: one write port, one read port with registered read data.
module kwm_head_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 74
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/kmer_k_way_merge_unit.sv
// An input transaction is taken when idle; one with no result frees the port after the check state.
// Each emitted record passes through check, a serial scan reading the head of every source in use,
// drain and emit; emit waits while the output is stalled. The serial scan of the head memory sets the cost.
// A waiting result does not block the next input transaction; the next emission waits for it.
// Reset (synchronous, active low) clears all head-full and ended flags and sets sources_in_use
// to 16; the head memory itself is not cleared and needs no clearing pass.
module kmer_k_way_merge_unit #(
    parameter int SOURCES   = kwm_pkg::SOURCES_DEF,
    parameter int KEY_BASES = kwm_pkg::KEY_BASES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input record channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [kwm_pkg::SRC_W-1:0]       i_source,
    input  logic [kwm_pkg::KEY_FIELD_W-1:0] i_key,
    input  logic [kwm_pkg::POS_W-1:0]       i_position,
    input  logic                           i_has_record,
    input  logic                           i_last_of_source,
    // merged output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [kwm_pkg::KEY_FIELD_W-1:0] o_out_key,
    output logic [kwm_pkg::POS_W-1:0]       o_out_position,
    output logic [kwm_pkg::SRC_W-1:0]       o_out_source,
    output logic                           o_merge_done,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kwm_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int IDX_W    = $clog2(SOURCES);
    localparam int LIVE_MAX = (SOURCES < kwm_pkg::SRC_REACH) ? SOURCES : kwm_pkg::SRC_REACH;
    localparam int KEY_W    = (2 * KEY_BASES < kwm_pkg::KEY_FIELD_W) ?
                              2 * KEY_BASES : kwm_pkg::KEY_FIELD_W;
    localparam int DATA_W   = KEY_W + kwm_pkg::POS_W;

    kwm_pkg::t_state r_state, n_state;

    logic [SOURCES-1:0]        r_full, n_full;
    logic [SOURCES-1:0]        r_ended, n_ended;
    logic [kwm_pkg::CFG_W-1:0] r_cfg, n_cfg;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]          r_cmp_idx, n_cmp_idx;
    logic                      r_best_vld, n_best_vld;
    logic [KEY_W-1:0]          r_best_key, n_best_key;
    logic [kwm_pkg::POS_W-1:0] r_best_pos, n_best_pos;
    logic [IDX_W-1:0]          r_best_idx, n_best_idx;
    logic                      r_out_valid, n_out_valid;
    logic [KEY_W-1:0]          r_out_key, n_out_key;
    logic [kwm_pkg::POS_W-1:0] r_out_pos, n_out_pos;
    logic [IDX_W-1:0]          r_out_src, n_out_src;
    logic                      r_out_done, n_out_done;

    logic [kwm_pkg::CFG_W-1:0] w_live;
    logic [SOURCES-1:0]        w_in_use;
    logic [SOURCES-1:0]        w_best_mask;
    logic [SOURCES-1:0]        w_full_after;
    logic                      w_ready_all;
    logic                      w_any_full;
    logic                      w_done;
    logic                      w_in_accept;
    logic [IDX_W-1:0]          w_src_idx;
    logic                      w_src_take;
    logic                      w_emit_ok;
    logic                      w_we;
    logic [DATA_W-1:0]         w_rdata;
    logic [KEY_W-1:0]          w_rd_key;
    logic [kwm_pkg::POS_W-1:0] w_rd_pos;

    // Effective source count: zero acts as one, and the count saturates at min(SOURCES, reach).
    always_comb begin
        if (r_cfg == '0) begin
            w_live = kwm_pkg::CFG_W'(1);
        end else if (r_cfg > kwm_pkg::CFG_W'(LIVE_MAX)) begin
            w_live = kwm_pkg::CFG_W'(LIVE_MAX);
        end else begin
            w_live = r_cfg;
        end
    end

    always_comb begin
        for (int i = 0; i < SOURCES; i++) begin
            w_in_use[i] = (i < int'(w_live));
        end
    end

    assign w_best_mask  = SOURCES'(1) << r_best_idx;
    assign w_full_after = r_full & ~w_best_mask;
    assign w_ready_all  = &(r_full | r_ended | ~w_in_use);
    assign w_any_full   = |(r_full & w_in_use);
    assign w_done       = &((~w_full_after & r_ended) | ~w_in_use);

    assign o_stall     = (r_state != kwm_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == kwm_pkg::S_IDLE);
    assign w_in_accept = i_valid && !o_stall;
    assign w_src_idx   = IDX_W'(i_source);
    assign w_src_take  = ({1'b0, i_source} < w_live) && !r_full[w_src_idx]
                         && !r_ended[w_src_idx];
    assign w_emit_ok   = !r_out_valid || !i_stall;
    assign w_we        = w_in_accept && w_src_take && i_has_record;

    kwm_head_ram #(
        .DEPTH  (SOURCES),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_src_idx),
        .i_wdata ({i_key[KEY_W-1:0], i_position}),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd_key = w_rdata[DATA_W-1:kwm_pkg::POS_W];
    assign w_rd_pos = w_rdata[kwm_pkg::POS_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_full      = r_full;
        n_ended     = r_ended;
        n_cfg       = r_cfg;
        n_idx       = r_idx;
        n_best_vld  = r_best_vld;
        n_best_key  = r_best_key;
        n_best_pos  = r_best_pos;
        n_best_idx  = r_best_idx;
        n_out_valid = r_out_valid;
        n_out_key   = r_out_key;
        n_out_pos   = r_out_pos;
        n_out_src   = r_out_src;
        n_out_done  = r_out_done;
        n_cmp_vld   = (r_state == kwm_pkg::S_SCAN);
        n_cmp_idx   = r_idx;

        if (i_cfg_valid && o_cfg_ready) begin
            n_cfg = i_cfg_data;
        end

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        // Read data of the previous scan cycle; strict compare keeps the lowest index on ties.
        if (r_cmp_vld && r_full[r_cmp_idx] && (!r_best_vld || w_rd_key < r_best_key)) begin
            n_best_vld = 1'b1;
            n_best_key = w_rd_key;
            n_best_pos = w_rd_pos;
            n_best_idx = r_cmp_idx;
        end

        unique case (r_state)
            kwm_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    if (w_src_take) begin
                        if (i_has_record) begin
                            n_full[w_src_idx] = 1'b1;
                        end
                        if (i_last_of_source) begin
                            n_ended[w_src_idx] = 1'b1;
                        end
                    end
                    n_state = kwm_pkg::S_CHECK;
                end
            end
            kwm_pkg::S_CHECK: begin
                if (!w_ready_all) begin
                    n_state = kwm_pkg::S_IDLE;
                end else if (!w_any_full) begin
                    // Every source ended with nothing held: an empty merge.
                    n_ended = '0;
                    n_state = kwm_pkg::S_IDLE;
                end else begin
                    n_idx      = '0;
                    n_best_vld = 1'b0;
                    n_state    = kwm_pkg::S_SCAN;
                end
            end
            kwm_pkg::S_SCAN: begin
                if (r_idx == IDX_W'(w_live - kwm_pkg::CFG_W'(1))) begin
                    n_state = kwm_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            kwm_pkg::S_DRAIN: begin
                n_state = kwm_pkg::S_EMIT;
            end
            kwm_pkg::S_EMIT: begin
                if (w_emit_ok) begin
                    n_out_valid = 1'b1;
                    n_out_key   = r_best_key;
                    n_out_pos   = r_best_pos;
                    n_out_src   = r_best_idx;
                    n_out_done  = w_done;
                    n_full      = w_full_after;
                    if (w_done) begin
                        n_ended = '0;
                        n_state = kwm_pkg::S_IDLE;
                    end else if (r_ended[r_best_idx]) begin
                        n_state = kwm_pkg::S_CHECK;
                    end else begin
                        n_state = kwm_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = kwm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kwm_pkg::S_IDLE;
            r_full      <= '0;
            r_ended     <= '0;
            r_cfg       <= kwm_pkg::CFG_RESET;
            r_cmp_vld   <= 1'b0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_full      <= n_full;
            r_ended     <= n_ended;
            r_cfg       <= n_cfg;
            r_cmp_vld   <= n_cmp_vld;
            r_best_vld  <= n_best_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_best_key <= n_best_key;
        r_best_pos <= n_best_pos;
        r_best_idx <= n_best_idx;
        r_out_key  <= n_out_key;
        r_out_pos  <= n_out_pos;
        r_out_src  <= n_out_src;
        r_out_done <= n_out_done;
    end

    assign o_valid        = r_out_valid;
    assign o_out_key      = kwm_pkg::KEY_FIELD_W'(r_out_key);
    assign o_out_position = r_out_pos;
    assign o_out_source   = kwm_pkg::SRC_W'(r_out_src);
    assign o_merge_done   = r_out_done;

endmodule
